// ===== rtl/core/escfd_pkg.sv =====
package escfd_pkg;

	localparam logic [7:0] SOF_BYTE = 8'h21;
	localparam logic [7:0] EOF_BYTE = 8'h3B;
	localparam logic [7:0] ESC_BYTE = 8'h5C;
	localparam logic [7:0] ESC_SOF  = 8'h25;
	localparam logic [7:0] ESC_EOF  = 8'h5E;

	localparam logic [7:0] POLY_RESET    = 8'hA6;
	localparam logic [6:0] MAX_LEN_RESET = 7'd126;
	localparam logic [6:0] MIN_COUNT     = 7'd2;

	typedef enum logic [0:0] {
		REG_CRC_POLY = 1'b0,
		REG_MAX_LEN  = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_SHORT    = 2'd2,
		ST_LONG     = 2'd3
	} frame_status_t;

	typedef enum logic [0:0] {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} result_kind_t;

	typedef struct packed {
		result_kind_t  kind;
		logic [7:0]    payload_byte;
		frame_status_t status;
		logic [6:0]    payload_length;
	} result_t;

	typedef struct packed {
		logic [7:0] crc_polynomial;
		logic [6:0] max_decoded_bytes;
	} cfg_t;

endpackage

// ===== rtl/core/escfd_crc8.sv =====
module escfd_crc8 (
	input  logic [7:0] crc,
	input  logic [7:0] data,
	input  logic [7:0] poly,
	output logic [7:0] crc_next
);

	// MSB-first fold of one byte, one shift per bit.
	always_comb begin
		logic [7:0] v;
		v = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ poly;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		crc_next = v;
	end

endmodule

// ===== rtl/core/escfd_decoder.sv =====
module escfd_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           rx_byte,
	input  escfd_pkg::cfg_t      cfg,
	output logic                 res_valid,
	output escfd_pkg::result_t   res
);

	logic       in_frame_q, escape_q;
	logic [6:0] count_q;
	logic [7:0] held_q, crc_q;

	logic       in_frame_n, escape_n;
	logic [6:0] count_n;
	logic [7:0] held_n, crc_n;
	logic [7:0] crc_fold;
	logic [7:0] dec_byte;
	logic       dec_ok;

	escfd_crc8 u_crc (
		.crc      (crc_q),
		.data     (held_q),
		.poly     (cfg.crc_polynomial),
		.crc_next (crc_fold)
	);

	always_comb begin
		in_frame_n = in_frame_q;
		escape_n   = escape_q;
		count_n    = count_q;
		held_n     = held_q;
		crc_n      = crc_q;
		res_valid  = 1'b0;
		res        = '0;
		dec_byte   = rx_byte;
		dec_ok     = 1'b0;

		if (rx_byte == escfd_pkg::SOF_BYTE) begin
			in_frame_n = 1'b1;
			escape_n   = 1'b0;
			count_n    = '0;
			held_n     = '0;
			crc_n      = '0;
		end else if (in_frame_q) begin
			if (rx_byte == escfd_pkg::EOF_BYTE) begin
				in_frame_n = 1'b0;
				escape_n   = 1'b0;
				res_valid  = 1'b1;
				res.kind   = escfd_pkg::KIND_STATUS;
				if (count_q > escfd_pkg::MIN_COUNT) begin
					res.status = (held_q == crc_q) ? escfd_pkg::ST_OK
						: escfd_pkg::ST_MISMATCH;
					res.payload_length = count_q - 7'd1;
				end else begin
					res.status = escfd_pkg::ST_SHORT;
				end
			end else if (!escape_q) begin
				if (rx_byte == escfd_pkg::ESC_BYTE) begin
					escape_n = 1'b1;
				end else begin
					dec_ok = 1'b1;
				end
			end else begin
				escape_n = 1'b0;
				case (rx_byte)
					escfd_pkg::ESC_SOF: begin
						dec_byte = escfd_pkg::SOF_BYTE;
						dec_ok   = 1'b1;
					end
					escfd_pkg::ESC_EOF: begin
						dec_byte = escfd_pkg::EOF_BYTE;
						dec_ok   = 1'b1;
					end
					escfd_pkg::ESC_BYTE: begin
						dec_byte = escfd_pkg::ESC_BYTE;
						dec_ok   = 1'b1;
					end
					default: begin
						in_frame_n = 1'b0;
					end
				endcase
			end

			if (dec_ok) begin
				if (count_q >= cfg.max_decoded_bytes) begin
					in_frame_n = 1'b0;
					escape_n   = 1'b0;
					res_valid  = 1'b1;
					res.kind   = escfd_pkg::KIND_STATUS;
					res.status = escfd_pkg::ST_LONG;
					res.payload_length = (cfg.max_decoded_bytes == '0) ? '0
						: cfg.max_decoded_bytes - 7'd1;
				end else if (count_q != '0) begin
					res_valid        = 1'b1;
					res.kind         = escfd_pkg::KIND_PAYLOAD;
					res.payload_byte = held_q;
					crc_n            = crc_fold;
					held_n           = dec_byte;
					count_n          = count_q + 7'd1;
				end else begin
					held_n  = dec_byte;
					count_n = 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			escape_q   <= 1'b0;
			count_q    <= '0;
			held_q     <= '0;
			crc_q      <= '0;
		end else if (fire) begin
			in_frame_q <= in_frame_n;
			escape_q   <= escape_n;
			count_q    <= count_n;
			held_q     <= held_n;
			crc_q      <= crc_n;
		end
	end

endmodule

// ===== rtl/core/escaped_frame_crc8_deframer.sv =====
// Path: an accepted input word is captured in the input register, then decoded into the
// output register once that register is empty or being drained; a stalled output holds the
// input register and blocks the slave side. The CRC fold is a combinational eight-step
// XOR chain. Throughput: one input word per cycle unless the output stalls.
// Reset (arst_n low, asynchronous): no frame open, CRC polynomial 0xA6, length limit 126,
// both stream stages empty.
module escaped_frame_crc8_deframer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [9:8] frame_status,
	                                    // [16:10] payload_length, [23:17] zero
	output logic        m_axis_tuser,   // [0] result_kind

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);

	escfd_pkg::cfg_t    cfg_q;

	logic               valid_s1;
	logic [7:0]         byte_s1;

	logic               out_valid_q;
	escfd_pkg::result_t out_res_q;

	logic               s1_fire;
	logic               res_valid;
	escfd_pkg::result_t res;

	// Configuration registers; user writes only while the block is idle, unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_polynomial    <= escfd_pkg::POLY_RESET;
			cfg_q.max_decoded_bytes <= escfd_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			case (escfd_pkg::reg_index_t'(cfg_index))
				escfd_pkg::REG_CRC_POLY: cfg_q.crc_polynomial    <= cfg_wdata;
				escfd_pkg::REG_MAX_LEN:  cfg_q.max_decoded_bytes <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// Advance the stage-1 word into the decoder whenever the output register
	// is empty or being drained this cycle; words with no result advance too.
	assign s1_fire       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload register: hold while stalled.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Decoder: frame state, escape handling, hold-back and CRC.
	escfd_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (s1_fire),
		.rx_byte   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: load on a decoded result, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.kind;
	assign m_axis_tdata  = {7'd0, out_res_q.payload_length, out_res_q.status,
		out_res_q.payload_byte};

`ifndef SYNTHESIS
	// A held stage-1 word behind a stalled output must block the slave side.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while pipeline is stalled");

	// A pending result under a stalled output must stay valid and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_res_q)))
		else $error("pending result changed under stall");

	// A payload word carries no status or length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_res_q.kind == escfd_pkg::KIND_PAYLOAD) |->
		(out_res_q.status == escfd_pkg::ST_OK && out_res_q.payload_length == '0))
		else $error("payload word with nonzero status fields");

	// A too-short frame reports zero length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_res_q.kind == escfd_pkg::KIND_STATUS &&
		out_res_q.status == escfd_pkg::ST_SHORT) |-> (out_res_q.payload_length == '0))
		else $error("short frame with nonzero length");
`endif

endmodule
